@@ design/ufcp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ufcp_pkg;

  localparam int unsigned DEFAULT_STORE_DEPTH = 32;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] HEAD_FLAG_RESET = 8'd170;
  localparam logic [BYTE_W-1:0] END_FLAG_RESET  = 8'd85;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_FLAG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_FLAG  = 2'd1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_OVERFLOW = 2'd3
  } frame_status_t;

  typedef enum logic [1:0] {
    S_RECV,
    S_FINISH,
    S_READ,
    S_LOAD
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_byte;
    logic load_err;
    logic load_data;
    logic rd_start;
    logic rd_issue;
    logic rd_inc;
    logic clear_frame;
  } ufcp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic          is_end;
    frame_status_t err;
    logic          slot_free;
    logic          rd_last;
  } ufcp_status_t;

endpackage

`default_nettype wire

@@ design/uart_frame_checksum_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Input words are taken without a stall; only the end flag of a frame holds
// the input off. A failed frame gives its single error word from the finish
// state once the output is free. A good frame reads each payload word from
// the registered read port of the frame store, then loads it once the output
// is free. Synchronous reset sets the flags to 170 and 85 and returns to
// waiting for a head flag; the frame store contents are not cleared.
module uart_frame_checksum_parser #(
  parameter int unsigned STORE_DEPTH = ufcp_pkg::DEFAULT_STORE_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [ufcp_pkg::BYTE_W-1:0]    rx_byte,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [ufcp_pkg::BYTE_W-1:0]         payload_byte,
  output logic [1:0]                          frame_status,
  output logic                                last_of_frame,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ufcp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ufcp_pkg::BYTE_W-1:0]    cfg_data
);

  ufcp_pkg::ufcp_cmd_t    cmd;
  ufcp_pkg::ufcp_status_t status;

  assign cfg_ready = 1'b1;

  ufcp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ufcp_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .rx_byte       (rx_byte),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .payload_byte  (payload_byte),
    .frame_status  (frame_status),
    .last_of_frame (last_of_frame)
  );

endmodule

`default_nettype wire

@@ design/ufcp_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ufcp_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire ufcp_pkg::ufcp_status_t status,
  output ufcp_pkg::ufcp_cmd_t        cmd
);

  ufcp_pkg::ctrl_state_t state;
  ufcp_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ufcp_pkg::S_RECV;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ufcp_pkg::S_RECV: begin
        in_stall      = 1'b0;
        cmd.take_byte = in_valid;
        if (in_valid && status.is_end) begin
          state_next = ufcp_pkg::S_FINISH;
        end
      end
      ufcp_pkg::S_FINISH: begin
        if (status.err != ufcp_pkg::ST_OK) begin
          if (status.slot_free) begin
            cmd.load_err    = 1'b1;
            cmd.clear_frame = 1'b1;
            state_next      = ufcp_pkg::S_RECV;
          end
        end else begin
          cmd.rd_start = 1'b1;
          state_next   = ufcp_pkg::S_READ;
        end
      end
      ufcp_pkg::S_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = ufcp_pkg::S_LOAD;
      end
      ufcp_pkg::S_LOAD: begin
        if (status.slot_free) begin
          cmd.load_data = 1'b1;
          if (status.rd_last) begin
            cmd.clear_frame = 1'b1;
            state_next      = ufcp_pkg::S_RECV;
          end else begin
            cmd.rd_inc = 1'b1;
            state_next = ufcp_pkg::S_READ;
          end
        end
      end
      default: begin
        state_next = ufcp_pkg::S_RECV;
      end
    endcase
  end

  // A payload word is only loaded after its memory read was issued.
  a_load_after_read: assert property (@(posedge clk) disable iff (rst)
    state == ufcp_pkg::S_LOAD |->
      $past(state) == ufcp_pkg::S_READ || $past(state) == ufcp_pkg::S_LOAD)
    else $error("load state entered without a read");

  a_end_finishes: assert property (@(posedge clk) disable iff (rst)
    (state == ufcp_pkg::S_RECV && in_valid && status.is_end) |=>
      state == ufcp_pkg::S_FINISH)
    else $error("end flag did not start frame finish");

  a_clear_returns: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_frame |=> state == ufcp_pkg::S_RECV)
    else $error("frame cleared without returning to receive");

endmodule

`default_nettype wire

@@ design/ufcp_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ufcp_dp #(
  parameter int unsigned STORE_DEPTH = ufcp_pkg::DEFAULT_STORE_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire ufcp_pkg::ufcp_cmd_t               cmd,
  output ufcp_pkg::ufcp_status_t                 status,
  input  wire logic [ufcp_pkg::BYTE_W-1:0]       rx_byte,
  input  wire logic                              cfg_valid,
  input  wire logic                              cfg_ready,
  input  wire logic [ufcp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ufcp_pkg::BYTE_W-1:0]       cfg_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [ufcp_pkg::BYTE_W-1:0]            payload_byte,
  output logic [1:0]                             frame_status,
  output logic                                   last_of_frame
);

  localparam int unsigned CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STORE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);

  logic [ufcp_pkg::BYTE_W-1:0] head_flag;
  logic [ufcp_pkg::BYTE_W-1:0] end_flag;

  logic                        in_frame;
  logic [CNT_W-1:0]            byte_count;
  logic                        overflow_seen;
  logic [ufcp_pkg::BYTE_W-1:0] sum_all;
  logic [ufcp_pkg::BYTE_W-1:0] last_byte;

  logic [ufcp_pkg::BYTE_W-1:0] frame_store [STORE_DEPTH];
  logic [ADDR_W-1:0]           rd_idx;
  logic [ufcp_pkg::BYTE_W-1:0] rd_data;

  ufcp_pkg::frame_status_t     out_status;
  logic                        store_byte;
  logic [ufcp_pkg::BYTE_W-1:0] payload_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_flag <= ufcp_pkg::HEAD_FLAG_RESET;
      end_flag  <= ufcp_pkg::END_FLAG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ufcp_pkg::REG_HEAD_FLAG: head_flag <= cfg_data;
        ufcp_pkg::REG_END_FLAG:  end_flag  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign store_byte = cmd.take_byte && in_frame && (rx_byte != end_flag)
                      && (byte_count < DEPTH_CNT);

  // The running sum covers every stored byte including the checksum, so the
  // payload sum is that total minus the most recent byte.
  assign payload_sum = sum_all - last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      byte_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.clear_frame) begin
      in_frame      <= 1'b0;
      byte_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.take_byte) begin
      if (!in_frame) begin
        if (rx_byte == head_flag) begin
          in_frame      <= 1'b1;
          byte_count    <= '0;
          overflow_seen <= 1'b0;
        end
      end else if (rx_byte != end_flag) begin
        if (byte_count < DEPTH_CNT) begin
          byte_count <= byte_count + CNT_W'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte && !in_frame) begin
      sum_all <= '0;
    end else if (store_byte) begin
      sum_all   <= sum_all + rx_byte;
      last_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (store_byte) begin
      frame_store[byte_count[ADDR_W-1:0]] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_data <= frame_store[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_start) begin
      rd_idx <= '0;
    end else if (cmd.rd_inc) begin
      rd_idx <= rd_idx + ADDR_W'(1);
    end
  end

  always_comb begin
    status.is_end    = in_frame && (rx_byte == end_flag);
    status.slot_free = !out_valid || !out_stall;
    status.rd_last   = (CNT_W'(rd_idx) == byte_count - CNT_TWO);
    if (overflow_seen) begin
      status.err = ufcp_pkg::ST_OVERFLOW;
    end else if (byte_count < CNT_TWO) begin
      status.err = ufcp_pkg::ST_EMPTY;
    end else if (payload_sum != last_byte) begin
      status.err = ufcp_pkg::ST_MISMATCH;
    end else begin
      status.err = ufcp_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_err || cmd.load_data) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_err) begin
      payload_byte  <= '0;
      out_status    <= status.err;
      last_of_frame <= 1'b1;
    end else if (cmd.load_data) begin
      payload_byte  <= rd_data;
      out_status    <= ufcp_pkg::ST_OK;
      last_of_frame <= status.rd_last;
    end
  end

  assign frame_status = out_status;

  a_load_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load_err && cmd.load_data))
    else $error("error and payload words loaded together");

  a_data_only_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.load_data |-> status.err == ufcp_pkg::ST_OK)
    else $error("payload replayed for a failed frame");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    store_byte |=> byte_count == $past(byte_count) + CNT_W'(1)
                   && byte_count <= DEPTH_CNT)
    else $error("stored byte count out of step");

endmodule

`default_nettype wire
